@@ design/rsd_pkg.sv @@
// shared types, state codes and decoder transition table for the step divider
`default_nettype none

package rsd_pkg;

	localparam int unsigned TickW  = 8;
	localparam int unsigned CountW = TickW + 1;
	localparam int unsigned DataW  = 8;

	typedef enum logic [6:0] {
		ST_START     = 7'b0000001,
		ST_CW_FINAL  = 7'b0000010,
		ST_CW_BEGIN  = 7'b0000100,
		ST_CW_NEXT   = 7'b0001000,
		ST_CCW_BEGIN = 7'b0010000,
		ST_CCW_FINAL = 7'b0100000,
		ST_CCW_NEXT  = 7'b1000000
	} dec_state_t;

	typedef struct packed {
		dec_state_t state;
		logic       cw;
		logic       ccw;
	} dec_next_t;

	typedef struct packed {
		logic valid;
		logic cw;
	} step_res_t;

	// sel is {a, b}; a detent is reported only on the return to 11 idle
	function automatic dec_next_t dec_next(dec_state_t st, logic [1:0] sel);
		dec_next_t n;
		n.state = ST_START;
		n.cw    = 1'b0;
		n.ccw   = 1'b0;
		case (st)
			ST_CW_FINAL: begin
				case (sel)
					2'b00:   n.state = ST_CW_NEXT;
					2'b01:   n.state = ST_START;
					2'b10:   n.state = ST_CW_FINAL;
					default: begin
						n.state = ST_START;
						n.cw    = 1'b1;
					end
				endcase
			end
			ST_CW_BEGIN: begin
				case (sel)
					2'b00:   n.state = ST_CW_NEXT;
					2'b01:   n.state = ST_CW_BEGIN;
					default: n.state = ST_START;
				endcase
			end
			ST_CW_NEXT: begin
				case (sel)
					2'b00:   n.state = ST_CW_NEXT;
					2'b01:   n.state = ST_CW_BEGIN;
					2'b10:   n.state = ST_CW_FINAL;
					default: n.state = ST_START;
				endcase
			end
			ST_CCW_BEGIN: begin
				case (sel)
					2'b00:   n.state = ST_CCW_NEXT;
					2'b10:   n.state = ST_CCW_BEGIN;
					default: n.state = ST_START;
				endcase
			end
			ST_CCW_FINAL: begin
				case (sel)
					2'b00:   n.state = ST_CCW_NEXT;
					2'b01:   n.state = ST_CCW_FINAL;
					2'b10:   n.state = ST_START;
					default: begin
						n.state = ST_START;
						n.ccw   = 1'b1;
					end
				endcase
			end
			ST_CCW_NEXT: begin
				case (sel)
					2'b00:   n.state = ST_CCW_NEXT;
					2'b01:   n.state = ST_CCW_FINAL;
					2'b10:   n.state = ST_CCW_BEGIN;
					default: n.state = ST_START;
				endcase
			end
			default: begin
				// start state, and any code that cannot be reached
				case (sel)
					2'b01:   n.state = ST_CW_BEGIN;
					2'b10:   n.state = ST_CCW_BEGIN;
					default: n.state = ST_START;
				endcase
			end
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

@@ design/rsd_core.sv @@
// sample register, quadrature decoder and detent counter
`default_nettype none

module rsd_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      in_a,
	input  wire logic                      in_b,
	input  wire logic                      cfg_we,
	input  wire logic [rsd_pkg::TickW-1:0] cfg_wdata,
	input  wire logic                      out_free,
	output rsd_pkg::step_res_t             res,
	output logic                           res_load
);

	logic                               valid_s1;
	logic                               a_s1;
	logic                               b_s1;
	logic                               adv;
	rsd_pkg::dec_state_t                state_q;
	logic signed [rsd_pkg::CountW-1:0]  cnt_q;
	logic [rsd_pkg::TickW-1:0]          ticks_q;
	rsd_pkg::dec_next_t                 nxt;
	logic signed [rsd_pkg::CountW-1:0]  base;
	logic signed [rsd_pkg::CountW-1:0]  cnt_new;
	logic [rsd_pkg::CountW-1:0]         mag;
	logic                               detent;
	logic                               emit;

	assign adv      = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;
	assign res_load = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			a_s1 <= in_a;
			b_s1 <= in_b;
		end
	end

	always_comb begin
		nxt    = rsd_pkg::dec_next(state_q, {a_s1, b_s1});
		detent = nxt.cw || nxt.ccw;
		// a reversal drops whatever was counted the other way
		if (nxt.cw) begin
			base    = cnt_q[rsd_pkg::CountW-1] ? '0 : cnt_q;
			cnt_new = base + rsd_pkg::CountW'(1);
		end else begin
			base    = (cnt_q > 0) ? '0 : cnt_q;
			cnt_new = base - rsd_pkg::CountW'(1);
		end
		mag  = cnt_new[rsd_pkg::CountW-1] ? rsd_pkg::CountW'(-cnt_new)
		                                  : rsd_pkg::CountW'(cnt_new);
		// zero ticks behaves like one, since the magnitude is at least one
		emit = detent && (mag >= {1'b0, ticks_q});
		res.valid = emit;
		res.cw    = nxt.cw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsd_pkg::ST_START;
			cnt_q   <= '0;
		end else if (adv) begin
			state_q <= nxt.state;
			if (emit) begin
				cnt_q <= '0;
			end else if (detent) begin
				cnt_q <= cnt_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= rsd_pkg::TickW'(1);
		end else if (cfg_we) begin
			ticks_q <= cfg_wdata;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != {1'b1, {(rsd_pkg::CountW-1){1'b0}}})
		else $error("detent counter reached its negative limit");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && emit) |=> (cnt_q == '0))
		else $error("counter not cleared after a step");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> ($stable(state_q) && $stable(cnt_q)))
		else $error("decoder state moved while stalled");

	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && !out_free))
		else $error("input stalled without a pending sample");

endmodule

`default_nettype wire

@@ design/rsd_out.sv @@
// output register holding one step event until the receiver takes it
`default_nettype none

module rsd_out (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire rsd_pkg::step_res_t res,
	output logic                    out_free,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    out_cw
);

	logic valid_q;
	logic cw_q;

	assign out_free  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_cw    = cw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res.valid;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.valid) begin
			cw_q <= res.cw;
		end
	end

endmodule

`default_nettype wire

@@ design/rotary_encoder_step_divider.sv @@
// top level of the rotary encoder step divider
//
// s_* carries one sample of the encoder lines per request; a full-step
// decoder reports a detent when a complete sequence ends back at 11.
// Detents move a signed counter, cleared on reversal; when its magnitude
// reaches the programmed detents per step one step request with its direction
// leaves on m_* and the counter clears. Most samples produce no output request.
// The detents-per-step setting is written through cfg_we/cfg_wdata (0 acts as 1).
// A sample accepted into the sample register is decoded combinationally; its step
// request (if any) is loaded into the output register driving m_tvalid once free.
// One sample per cycle unless m_* stalls; the decoder/counter is a single stage.
// Reset (arst_n low) returns the decoder to its start state, clears the
// counter and the pending registers and sets detents per step to 1.
// When m_tready is low with a step pending, one more sample is held in the
// sample register and s_tready drops until the step is taken.
`default_nettype none

module rotary_encoder_step_divider (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [rsd_pkg::DataW-1:0] s_tdata,  // [0] line_a, [1] line_b
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [rsd_pkg::DataW-1:0]      m_tdata,  // [0] step_clockwise
	input  wire logic                      cfg_we,
	input  wire logic [rsd_pkg::TickW-1:0] cfg_wdata
);

	rsd_pkg::step_res_t res;
	logic               res_load;
	logic               out_free;
	logic               out_cw;

	rsd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_a      (s_tdata[0]),
		.in_b      (s_tdata[1]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_free  (out_free),
		.res       (res),
		.res_load  (res_load)
	);

	rsd_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.res       (res),
		.out_free  (out_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_cw    (out_cw)
	);

	assign m_tdata = {{(rsd_pkg::DataW-1){1'b0}}, out_cw};

endmodule

`default_nettype wire
